FILE: rtl/core/hmb_pkg.sv
`timescale 1ns / 1ps

package hmb_pkg;

  // Default largest grid side.
  localparam int MAX_SIDE_DEF = 256;

  // Field widths.
  localparam int CRD_W  = 9;
  localparam int HGT_W  = 32;
  localparam int STEP_W = 31;
  localparam int NRM_W  = 16;
  localparam int IDX_W  = 17;
  localparam int ACC_W  = 37;
  localparam int CFG_IW = 3;

  // Request modes.
  typedef enum logic [1:0] {
    MODE_STORE  = 2'd0,
    MODE_VERTEX = 2'd1,
    MODE_QUAD   = 2'd2
  } mode_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_WIDTH    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_LENGTH   = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_ORIGIN_Z = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_STEP     = 3'd4;

  // Request to the normal unit.
  typedef struct packed {
    logic                     start;
    logic signed [ACC_W-1:0]  sx;
    logic signed [ACC_W-1:0]  sz;
    logic [2:0]               n;
    logic [STEP_W-1:0]        step;
  } norm_req_t;

  // Response of the normal unit.
  typedef struct packed {
    logic                     done;
    logic signed [NRM_W-1:0]  nx;
    logic signed [NRM_W-1:0]  ny;
    logic signed [NRM_W-1:0]  nz;
  } norm_rsp_t;

endpackage

FILE: rtl/core/hmb_norm.sv
`timescale 1ns / 1ps

module hmb_norm (
  input  logic                clk,
  input  logic                rst_n,
  input  hmb_pkg::norm_req_t  req,
  output hmb_pkg::norm_rsp_t  rsp
);

  typedef enum logic [4:0] {
    N_IDLE  = 5'b00001,
    N_SHIFT = 5'b00010,
    N_SQ    = 5'b00100,
    N_ROOT  = 5'b01000,
    N_DIV   = 5'b10000
  } nstate_t;

  localparam int AW = hmb_pkg::ACC_W;
  localparam int NW = hmb_pkg::NRM_W;

  nstate_t            state_r;
  logic               done_r;
  logic [AW-1:0]      mag_r [3];
  logic               neg_r [3];
  logic [1:0]         k_r;
  logic [59:0]        prod_r;
  logic [61:0]        sum_r;
  logic [63:0]        v_r;
  logic [63:0]        res_r;
  logic [63:0]        bit_r;
  logic [31:0]        len_r;
  logic [4:0]         ds_r;
  logic [15:0]        num_r;
  logic [32:0]        rem_r;
  logic [15:0]        q_r;
  logic [NW-1:0]      nrm_r [3];

  logic [AW-1:0]      sx_mag, sz_mag, sy_mag;
  logic [63:0]        trial;
  logic [45:0]        numer;
  logic [32:0]        rem_sh;
  logic [NW-1:0]      q_sat;

  // Magnitudes of the incoming sum vector.
  always_comb begin
    sx_mag = req.sx < 0 ? AW'(-req.sx) : AW'(req.sx);
    sz_mag = req.sz < 0 ? AW'(-req.sz) : AW'(req.sz);
    sy_mag = AW'(req.n) * AW'(req.step);
  end

  // Root trial value, rounded numerator and one division step.
  always_comb begin
    trial  = res_r + bit_r;
    numer  = {1'b0, mag_r[k_r][29:0], 15'b0} + 46'(len_r >> 1);
    rem_sh = {rem_r[31:0], num_r[15]};
    if (neg_r[k_r]) begin
      q_sat = (q_r >= 16'h8000) ? 16'h8000 : NW'(16'h0 - q_r);
    end else begin
      q_sat = (q_r > 16'h7FFF) ? 16'h7FFF : q_r;
    end
  end

  // Sequencer: scale, sum of squares, root, then three divisions.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (req.start) begin
            mag_r[0] <= sx_mag;
            mag_r[1] <= sy_mag;
            mag_r[2] <= sz_mag;
            neg_r[0] <= req.sx < 0;
            neg_r[1] <= sy_mag != '0;
            neg_r[2] <= req.sz < 0;
            if (req.step == '0) begin
              nrm_r[0] <= '0;
              nrm_r[1] <= '0;
              nrm_r[2] <= '0;
              done_r   <= 1'b1;
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (mag_r[0][AW-1:30] != '0 || mag_r[1][AW-1:30] != '0 ||
              mag_r[2][AW-1:30] != '0) begin
            mag_r[0] <= mag_r[0] >> 1;
            mag_r[1] <= mag_r[1] >> 1;
            mag_r[2] <= mag_r[2] >> 1;
          end else begin
            k_r     <= 2'd0;
            sum_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          // Each product is registered, then accumulated in the next cycle.
          if (k_r != 2'd3) begin
            prod_r <= mag_r[k_r][29:0] * mag_r[k_r][29:0];
          end
          if (k_r != 2'd0) begin
            sum_r <= sum_r + 62'(prod_r);
          end
          if (k_r == 2'd3) begin
            v_r     <= 64'(sum_r + 62'(prod_r));
            res_r   <= '0;
            bit_r   <= 64'h4000_0000_0000_0000;
            state_r <= N_ROOT;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        N_ROOT: begin
          if (bit_r != '0) begin
            if (v_r >= trial) begin
              v_r   <= v_r - trial;
              res_r <= (res_r >> 1) + bit_r;
            end else begin
              res_r <= res_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end else if (res_r == '0) begin
            nrm_r[0] <= '0;
            nrm_r[1] <= '0;
            nrm_r[2] <= '0;
            done_r   <= 1'b1;
            state_r  <= N_IDLE;
          end else begin
            len_r   <= res_r[31:0];
            k_r     <= 2'd0;
            ds_r    <= '0;
            state_r <= N_DIV;
          end
        end
        N_DIV: begin
          if (ds_r == 5'd0) begin
            rem_r <= 33'(numer[45:16]);
            num_r <= numer[15:0];
            q_r   <= '0;
            ds_r  <= 5'd1;
          end else if (ds_r != 5'd17) begin
            num_r <= num_r << 1;
            if (rem_sh >= 33'(len_r)) begin
              rem_r <= rem_sh - 33'(len_r);
              q_r   <= {q_r[14:0], 1'b1};
            end else begin
              rem_r <= rem_sh;
              q_r   <= {q_r[14:0], 1'b0};
            end
            ds_r <= ds_r + 5'd1;
          end else begin
            nrm_r[k_r] <= q_sat;
            ds_r       <= '0;
            if (k_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              k_r <= k_r + 2'd1;
            end
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.nx   = nrm_r[0];
  assign rsp.ny   = nrm_r[1];
  assign rsp.nz   = nrm_r[2];

endmodule

FILE: rtl/core/heightmap_mesh_builder.sv
`timescale 1ns / 1ps

// Heightmap mesh builder. Requests arrive on the in_ channel (valid/stall):
// mode 0 stores a height sample, mode 1 asks for one vertex, mode 2 asks for
// the six corner indices of one quad. Results leave on the out_ channel
// (valid/stall), one item per cycle at most; out_last marks the final item
// of a request. Registers are written on the cfg_ channel (valid/ready),
// which is always ready. The user must write them only while the block is
// idle; the block itself does not enforce it. A store gives no result.
// A reject gives one item and a quad gives six. A vertex gives its item
// after reading the 3x3 neighborhood through the single read port of the
// height memory, six accumulation steps, up to five scaling shifts, the
// sum of squares, the bit-serial root and three divisions; with a zero
// step the normal unit returns a zero normal without them.
// One request is in work at a time; a new item is taken once the previous
// one has placed its last result in the output register.
// Reset restores the registers to their defaults; the height memory is not
// cleared. When the receiver stalls, the output item holds and the block
// waits before loading the next result.
module heightmap_mesh_builder #(
  parameter int MAX_SIDE = hmb_pkg::MAX_SIDE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [hmb_pkg::CRD_W-1:0]     in_row,
  input  logic [hmb_pkg::CRD_W-1:0]     in_col,
  input  logic signed [hmb_pkg::HGT_W-1:0] in_height_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic signed [31:0]            out_pos_x,
  output logic signed [31:0]            out_pos_y,
  output logic signed [31:0]            out_pos_z,
  output logic [hmb_pkg::CRD_W-1:0]     out_tex_u,
  output logic [hmb_pkg::CRD_W-1:0]     out_tex_v,
  output logic signed [hmb_pkg::NRM_W-1:0] out_norm_x,
  output logic signed [hmb_pkg::NRM_W-1:0] out_norm_y,
  output logic signed [hmb_pkg::NRM_W-1:0] out_norm_z,
  output logic [hmb_pkg::IDX_W-1:0]     out_vertex_index,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hmb_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [31:0]                   cfg_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int MAW   = $clog2(DEPTH);
  localparam int CW    = hmb_pkg::CRD_W;
  localparam int AW    = hmb_pkg::ACC_W;
  localparam int IW    = hmb_pkg::IDX_W;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_NORM = 7'b0001000,
    S_VOUT = 7'b0010000,
    S_QUAD = 7'b0100000,
    S_REJ  = 7'b1000000
  } state_t;

  state_t                  state_r;
  logic [CW-1:0]           width_r, length_r;
  logic [31:0]             origin_x_r, origin_z_r;
  logic [hmb_pkg::STEP_W-1:0] step_r;
  logic [CW-1:0]           r_r, c_r;
  logic [IW-1:0]           base_r;
  logic [3:0]              ki_r;
  logic [2:0]              slot_r;
  logic [2:0]              qk_r;
  logic signed [AW-1:0]    sx_r, sz_r;
  logic [2:0]              n_r;
  logic                    nstart_r;
  logic signed [31:0]      h_r [9];
  logic [31:0]             mem [DEPTH];
  logic [31:0]             rd_data_r;

  logic                    ov_r;
  logic [1:0]              o_kind_r;
  logic [31:0]             o_px_r, o_py_r, o_pz_r;
  logic [CW-1:0]           o_u_r, o_v_r;
  logic [hmb_pkg::NRM_W-1:0] o_nx_r, o_ny_r, o_nz_r;
  logic [IW-1:0]           o_idx_r;
  logic                    o_last_r;

  logic [CW-1:0]           w, l;
  logic [CW:0]             w1;
  logic                    in_acc, out_free;
  logic                    st_ok, vx_ok;
  logic [MAW-1:0]          waddr, raddr;
  logic [CW:0]             tr, tc;
  logic [1:0]              di, dj;
  logic                    en;
  logic [3:0]              p1, p0, q1, q0;
  logic [39:0]             px_prod, pz_prod;
  logic [IW-1:0]           qidx;
  hmb_pkg::norm_req_t      nreq;
  hmb_pkg::norm_rsp_t      nrsp;

  // Clamped grid sides.
  always_comb begin
    if (width_r == '0) begin
      w = CW'(1);
    end else if (32'(width_r) > MAX_SIDE) begin
      w = CW'(MAX_SIDE);
    end else begin
      w = width_r;
    end
    if (length_r == '0) begin
      l = CW'(1);
    end else if (32'(length_r) > MAX_SIDE) begin
      l = CW'(MAX_SIDE);
    end else begin
      l = length_r;
    end
    w1 = (CW+1)'(w) + (CW+1)'(1);
  end

  assign in_stall  = state_r != S_IDLE;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !ov_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign st_ok     = in_row < l && in_col < w;
  assign vx_ok     = in_row <= l && in_col <= w;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= CW'(1);
      length_r   <= CW'(1);
      origin_x_r <= '0;
      origin_z_r <= '0;
      step_r     <= hmb_pkg::STEP_W'(65536);
    end else if (cfg_valid) begin
      case (cfg_index)
        hmb_pkg::CFG_WIDTH:    width_r    <= cfg_data[CW-1:0];
        hmb_pkg::CFG_LENGTH:   length_r   <= cfg_data[CW-1:0];
        hmb_pkg::CFG_ORIGIN_X: origin_x_r <= cfg_data;
        hmb_pkg::CFG_ORIGIN_Z: origin_z_r <= cfg_data;
        hmb_pkg::CFG_STEP:     step_r     <= cfg_data[hmb_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Neighborhood address: row and column offsets, clamped to the grid.
  always_comb begin
    case (ki_r)
      4'd0, 4'd1, 4'd2: di = 2'd0;
      4'd3, 4'd4, 4'd5: di = 2'd1;
      default:          di = 2'd2;
    endcase
    case (ki_r)
      4'd0, 4'd3, 4'd6: dj = 2'd0;
      4'd1, 4'd4, 4'd7: dj = 2'd1;
      default:          dj = 2'd2;
    endcase
    tr = (CW+1)'(r_r) + (CW+1)'(di);
    tr = (tr == '0) ? '0 : tr - (CW+1)'(1);
    if (tr >= (CW+1)'(l)) begin
      tr = (CW+1)'(l) - (CW+1)'(1);
    end
    tc = (CW+1)'(c_r) + (CW+1)'(dj);
    tc = (tc == '0) ? '0 : tc - (CW+1)'(1);
    if (tc >= (CW+1)'(w)) begin
      tc = (CW+1)'(w) - (CW+1)'(1);
    end
    raddr = MAW'(32'(tr) * MAX_SIDE + 32'(tc));
    waddr = MAW'(32'(in_row) * MAX_SIDE + 32'(in_col));
  end

  // Height memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (in_acc && in_mode == hmb_pkg::MODE_STORE && st_ok) begin
      mem[waddr] <= in_height_in;
    end
    rd_data_r <= mem[raddr];
  end

  // Triangle slot table: which neighbor differences each triangle adds.
  always_comb begin
    en = 1'b0;
    p1 = 4'd4; p0 = 4'd4; q1 = 4'd4; q0 = 4'd4;
    case (slot_r)
      3'd0: begin
        en = r_r < l && c_r < w;
        p1 = 4'd5; p0 = 4'd4; q1 = 4'd7; q0 = 4'd4;
      end
      3'd1: begin
        en = r_r < l && c_r != '0;
        p1 = 4'd4; p0 = 4'd3; q1 = 4'd6; q0 = 4'd3;
      end
      3'd2: begin
        en = r_r < l && c_r != '0;
        p1 = 4'd7; p0 = 4'd6; q1 = 4'd7; q0 = 4'd4;
      end
      3'd3: begin
        en = r_r != '0 && c_r < w;
        p1 = 4'd2; p0 = 4'd1; q1 = 4'd4; q0 = 4'd1;
      end
      3'd4: begin
        en = r_r != '0 && c_r < w;
        p1 = 4'd5; p0 = 4'd4; q1 = 4'd5; q0 = 4'd2;
      end
      3'd5: begin
        en = r_r != '0 && c_r != '0;
        p1 = 4'd4; p0 = 4'd3; q1 = 4'd4; q0 = 4'd1;
      end
      default: en = 1'b0;
    endcase
  end

  // Vertex position products and quad corner selection.
  always_comb begin
    px_prod = 40'(c_r) * 40'(step_r);
    pz_prod = 40'(r_r) * 40'(step_r);
    case (qk_r)
      3'd0:       qidx = base_r;
      3'd1, 3'd4: qidx = base_r + IW'(w1);
      3'd2, 3'd3: qidx = base_r + IW'(1);
      default:    qidx = base_r + IW'(w1) + IW'(1);
    endcase
  end

  // Request sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ov_r     <= 1'b0;
      nstart_r <= 1'b0;
    end else begin
      nstart_r <= 1'b0;
      if (!out_stall) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            r_r    <= in_row;
            c_r    <= in_col;
            base_r <= IW'(20'(in_row) * 20'(w1) + 20'(in_col));
            ki_r   <= '0;
            qk_r   <= '0;
            if (in_mode == hmb_pkg::MODE_STORE && st_ok) begin
              state_r <= S_IDLE;
            end else if (in_mode == hmb_pkg::MODE_VERTEX && vx_ok) begin
              state_r <= S_READ;
            end else if (in_mode == hmb_pkg::MODE_QUAD && st_ok) begin
              state_r <= S_QUAD;
            end else begin
              state_r <= S_REJ;
            end
          end
        end
        S_READ: begin
          // Address ki goes out this cycle; data of ki-1 is captured.
          if (ki_r != '0) begin
            h_r[ki_r - 4'd1] <= rd_data_r;
          end
          if (ki_r == 4'd9) begin
            slot_r  <= '0;
            sx_r    <= '0;
            sz_r    <= '0;
            n_r     <= '0;
            state_r <= S_ACC;
          end else begin
            ki_r <= ki_r + 4'd1;
          end
        end
        S_ACC: begin
          if (en) begin
            sx_r <= sx_r + AW'(h_r[p1]) - AW'(h_r[p0]);
            sz_r <= sz_r + AW'(h_r[q1]) - AW'(h_r[q0]);
            n_r  <= n_r + 3'd1;
          end
          if (slot_r == 3'd5) begin
            nstart_r <= 1'b1;
            state_r  <= S_NORM;
          end else begin
            slot_r <= slot_r + 3'd1;
          end
        end
        S_NORM: begin
          if (nrsp.done) begin
            state_r <= S_VOUT;
          end
        end
        S_VOUT: begin
          if (out_free) begin
            ov_r     <= 1'b1;
            o_kind_r <= hmb_pkg::KIND_VERTEX;
            o_px_r   <= origin_x_r + px_prod[31:0];
            o_py_r   <= h_r[4];
            o_pz_r   <= origin_z_r + pz_prod[31:0];
            o_u_r    <= c_r;
            o_v_r    <= CW'((CW+1)'(l) + (CW+1)'(1) - (CW+1)'(r_r));
            o_nx_r   <= nrsp.nx;
            o_ny_r   <= nrsp.ny;
            o_nz_r   <= nrsp.nz;
            o_idx_r  <= '0;
            o_last_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        S_QUAD: begin
          if (out_free) begin
            ov_r     <= 1'b1;
            o_kind_r <= hmb_pkg::KIND_INDEX;
            o_px_r   <= '0;
            o_py_r   <= '0;
            o_pz_r   <= '0;
            o_u_r    <= '0;
            o_v_r    <= '0;
            o_nx_r   <= '0;
            o_ny_r   <= '0;
            o_nz_r   <= '0;
            o_idx_r  <= qidx;
            o_last_r <= qk_r == 3'd5;
            if (qk_r == 3'd5) begin
              state_r <= S_IDLE;
            end else begin
              qk_r <= qk_r + 3'd1;
            end
          end
        end
        S_REJ: begin
          if (out_free) begin
            ov_r     <= 1'b1;
            o_kind_r <= hmb_pkg::KIND_REJECT;
            o_px_r   <= '0;
            o_py_r   <= '0;
            o_pz_r   <= '0;
            o_u_r    <= '0;
            o_v_r    <= '0;
            o_nx_r   <= '0;
            o_ny_r   <= '0;
            o_nz_r   <= '0;
            o_idx_r  <= '0;
            o_last_r <= 1'b1;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Normal unit.
  assign nreq.start = nstart_r;
  assign nreq.sx    = sx_r;
  assign nreq.sz    = sz_r;
  assign nreq.n     = n_r;
  assign nreq.step  = step_r;

  hmb_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (nreq),
    .rsp   (nrsp)
  );

  assign out_valid        = ov_r;
  assign out_kind         = o_kind_r;
  assign out_pos_x        = o_px_r;
  assign out_pos_y        = o_py_r;
  assign out_pos_z        = o_pz_r;
  assign out_tex_u        = o_u_r;
  assign out_tex_v        = o_v_r;
  assign out_norm_x       = o_nx_r;
  assign out_norm_y       = o_ny_r;
  assign out_norm_z       = o_nz_r;
  assign out_vertex_index = o_idx_r;
  assign out_last         = o_last_r;

endmodule
